// ===== design/mtft_pkg.sv =====
// Shared constants and register codes for the multi-turn encoder feedback tracker.
package mtft_pkg;

    // Encoder and turn counter geometry
    localparam int COUNTS_PER_TURN = 8192;
    localparam int TURN_BITS       = 20;
    localparam int POS_W           = $clog2(COUNTS_PER_TURN);
    localparam int TOTAL_W         = TURN_BITS + POS_W + 1;

    // Field widths
    localparam int SPEED_W  = 16;
    localparam int TORQUE_W = 16;
    localparam int TEMP_W   = 8;
    localparam int ANGLE_W  = 39;
    localparam int RATE_W   = 29;
    localparam int OFS_W    = 14;
    localparam int GAIN_W   = 32;
    localparam int GAIN_H_W = GAIN_W / 2;
    localparam int Q_FRAC   = 16;

    // APB
    localparam int APB_DW = 32;
    localparam int ADDR_W = 4;

    // Register indexes (paddr word index)
    localparam logic [1:0] REG_OFFSET     = 2'd0;
    localparam logic [1:0] REG_ANGLE_GAIN = 2'd1;
    localparam logic [1:0] REG_RATE_GAIN  = 2'd2;

    // Register reset values
    localparam logic signed [OFS_W-1:0] OFFSET_RST     = '0;
    localparam logic [GAIN_W-1:0]       ANGLE_GAIN_RST = 32'd3294199;
    localparam logic [GAIN_W-1:0]       RATE_GAIN_RST  = 32'd449767923;

    // Opcodes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Half-turn thresholds on the position difference
    localparam logic signed [POS_W:0] HALF_POS = (POS_W + 1)'(COUNTS_PER_TURN / 2);
    localparam logic signed [POS_W:0] HALF_NEG = -HALF_POS;

    // Turn counter limits
    localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS - 1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS - 1){1'b0}}};

    // Output clamp limits
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W - 1){1'b1}}};
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W - 1){1'b0}}};
    localparam logic signed [RATE_W-1:0]  RATE_MAX  = {1'b0, {(RATE_W - 1){1'b1}}};
    localparam logic signed [RATE_W-1:0]  RATE_MIN  = {1'b1, {(RATE_W - 1){1'b0}}};

    // Round-half-up bias for Q16 rescaling
    localparam int ROUND_HALF = 1 << (Q_FRAC - 1);

endpackage

// ===== design/mtft_fb_if.sv =====
// Feedback input channel: valid/ready handshake with frame or tick payload.
interface mtft_fb_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   opcode;
    logic [mtft_pkg::POS_W-1:0]             position_raw;
    logic signed [mtft_pkg::SPEED_W-1:0]    speed_rpm;
    logic signed [mtft_pkg::TORQUE_W-1:0]   torque_raw;
    logic [mtft_pkg::TEMP_W-1:0]            temperature;

    modport source (
        output valid, opcode, position_raw, speed_rpm, torque_raw, temperature,
        input  ready
    );
    modport sink (
        input  valid, opcode, position_raw, speed_rpm, torque_raw, temperature,
        output ready
    );
endinterface

// ===== design/mtft_res_if.sv =====
// Result output channel: valid/ready handshake with position, angle and rate payload.
interface mtft_res_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [mtft_pkg::TOTAL_W-1:0]    total_count;
    logic signed [mtft_pkg::ANGLE_W-1:0]    angle_q16;
    logic signed [mtft_pkg::RATE_W-1:0]     rate_q16;
    logic signed [mtft_pkg::TORQUE_W-1:0]   torque_out;
    logic [mtft_pkg::TEMP_W-1:0]            temperature_out;
    logic                                   link_alive;

    modport source (
        output valid, total_count, angle_q16, rate_q16, torque_out, temperature_out,
               link_alive,
        input  ready
    );
    modport sink (
        input  valid, total_count, angle_q16, rate_q16, torque_out, temperature_out,
               link_alive,
        output ready
    );
endinterface

// ===== design/multiturn_encoder_feedback_tracker.sv =====
// Multi-turn encoder unwrap with angle and rate scaling, top level.
// Three register stages: input, unwrap/total, scaled result.
// Throughput: one word per cycle while o_res is ready.
// Each stage advances when the next is empty or moving.
// The scaling stage holds two 34x17 multipliers and one 16x33 multiplier.
// Reset (i_rst_n low, synchronous): pipeline empties, turn state and latched frame
//   data clear to zero, config registers return to their defaults.
module multiturn_encoder_feedback_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mtft_fb_if.sink                           i_fb,
    mtft_res_if.source                        o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mtft_pkg::ADDR_W-1:0]       paddr,
    input  logic [mtft_pkg::APB_DW-1:0]       pwdata,
    output logic [mtft_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    // Product widths for the scaling stage
    localparam int PA_W  = mtft_pkg::TOTAL_W + mtft_pkg::GAIN_H_W + 1;
    localparam int SUM_W = PA_W + 1;
    localparam int PR_W  = mtft_pkg::SPEED_W + mtft_pkg::GAIN_W + 1;

    //------------------------------------------------------------------
    // Config registers (APB, zero-wait)
    //------------------------------------------------------------------
    logic signed [mtft_pkg::OFS_W-1:0] r_offset;
    logic [mtft_pkg::GAIN_W-1:0]       r_angle_gain;
    logic [mtft_pkg::GAIN_W-1:0]       r_rate_gain;
    logic                              w_cfg_wr;
    logic [1:0]                        w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[mtft_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= mtft_pkg::OFFSET_RST;
            r_angle_gain <= mtft_pkg::ANGLE_GAIN_RST;
            r_rate_gain  <= mtft_pkg::RATE_GAIN_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                mtft_pkg::REG_OFFSET:     r_offset     <= pwdata[mtft_pkg::OFS_W-1:0];
                mtft_pkg::REG_ANGLE_GAIN: r_angle_gain <= pwdata;
                mtft_pkg::REG_RATE_GAIN:  r_rate_gain  <= pwdata;
                default: ;  // unmapped word, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            mtft_pkg::REG_OFFSET:     prdata = mtft_pkg::APB_DW'(r_offset);
            mtft_pkg::REG_ANGLE_GAIN: prdata = r_angle_gain;
            mtft_pkg::REG_RATE_GAIN:  prdata = r_rate_gain;
            default:                  prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when it drains
    //------------------------------------------------------------------
    logic r_s1_vld, r_s2_vld, r_s3_vld;
    logic w_rdy1, w_rdy2, w_rdy3;
    logic w_adv1, w_adv2, w_adv3;

    assign w_rdy3 = !r_s3_vld || o_res.ready;
    assign w_rdy2 = !r_s2_vld || w_rdy3;
    assign w_rdy1 = !r_s1_vld || w_rdy2;
    assign w_adv1 = i_fb.valid && w_rdy1;
    assign w_adv2 = r_s1_vld && w_rdy2;
    assign w_adv3 = r_s2_vld && w_rdy3;

    assign i_fb.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (w_rdy1) r_s1_vld <= i_fb.valid;
            if (w_rdy2) r_s2_vld <= r_s1_vld;
            if (w_rdy3) r_s3_vld <= r_s2_vld;
        end
    end

    //------------------------------------------------------------------
    // Stage 1: input register
    //------------------------------------------------------------------
    logic                                r_s1_op;
    logic [mtft_pkg::POS_W-1:0]          r_s1_pos;
    logic signed [mtft_pkg::SPEED_W-1:0] r_s1_speed;
    logic signed [mtft_pkg::TORQUE_W-1:0] r_s1_torque;
    logic [mtft_pkg::TEMP_W-1:0]         r_s1_temp;

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_op     <= i_fb.opcode;
            r_s1_pos    <= i_fb.position_raw;
            r_s1_speed  <= i_fb.speed_rpm;
            r_s1_torque <= i_fb.torque_raw;
            r_s1_temp   <= i_fb.temperature;
        end
    end

    //------------------------------------------------------------------
    // Stage 2: unwrap and total count. Tracking state moves with the word
    // leaving stage 1, so consecutive words see each other's updates.
    //------------------------------------------------------------------
    logic [mtft_pkg::POS_W-1:0]           r_prev, n_prev;
    logic signed [mtft_pkg::TURN_BITS-1:0] r_turn, n_turn;
    logic signed [mtft_pkg::TORQUE_W-1:0] r_torque, n_torque;
    logic [mtft_pkg::TEMP_W-1:0]          r_temp, n_temp;
    logic                                 r_seen, n_seen;
    logic                                 r_alive, n_alive;
    logic signed [mtft_pkg::POS_W:0]      w_delta;
    logic signed [mtft_pkg::TOTAL_W-1:0]  n_total;

    // Difference of two unsigned counts, one guard bit for the sign
    assign w_delta = $signed({1'b0, r_s1_pos} - {1'b0, r_prev});

    always_comb begin
        n_prev   = r_prev;
        n_turn   = r_turn;
        n_torque = r_torque;
        n_temp   = r_temp;
        n_seen   = r_seen;
        n_alive  = r_alive;
        if (r_s1_op == mtft_pkg::OP_FRAME) begin
            n_prev   = r_s1_pos;
            n_torque = r_s1_torque;
            n_temp   = r_s1_temp;
            n_seen   = 1'b1;
            // Forward wrap past zero: one turn up. Backward wrap: one turn down.
            // Exactly half a turn counts as no wrap. Counter saturates.
            if (w_delta < mtft_pkg::HALF_NEG) begin
                if (r_turn != mtft_pkg::TURN_MAX) begin
                    n_turn = r_turn + mtft_pkg::TURN_BITS'(1);
                end
            end else if (w_delta > mtft_pkg::HALF_POS) begin
                if (r_turn != mtft_pkg::TURN_MIN) begin
                    n_turn = r_turn - mtft_pkg::TURN_BITS'(1);
                end
            end
        end else begin
            // Watchdog tick: latch whether any frame came in this period
            n_alive = r_seen;
            n_seen  = 1'b0;
        end
    end

    // turns * counts_per_turn + position + offset; the width holds every case
    assign n_total = $signed({n_turn[mtft_pkg::TURN_BITS-1], n_turn,
                              {mtft_pkg::POS_W{1'b0}}})
                   + $signed(mtft_pkg::TOTAL_W'(n_prev))
                   + mtft_pkg::TOTAL_W'(r_offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_turn   <= '0;
            r_torque <= '0;
            r_temp   <= '0;
            r_seen   <= 1'b0;
            r_alive  <= 1'b0;
        end else if (w_adv2) begin
            r_prev   <= n_prev;
            r_turn   <= n_turn;
            r_torque <= n_torque;
            r_temp   <= n_temp;
            r_seen   <= n_seen;
            r_alive  <= n_alive;
        end
    end

    logic                                 r_s2_op;
    logic signed [mtft_pkg::TOTAL_W-1:0]  r_s2_total;
    logic signed [mtft_pkg::SPEED_W-1:0]  r_s2_speed;
    logic signed [mtft_pkg::TORQUE_W-1:0] r_s2_torque;
    logic [mtft_pkg::TEMP_W-1:0]          r_s2_temp;
    logic                                 r_s2_alive;

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_s2_op     <= r_s1_op;
            r_s2_total  <= n_total;
            r_s2_speed  <= r_s1_speed;
            r_s2_torque <= n_torque;
            r_s2_temp   <= n_temp;
            r_s2_alive  <= n_alive;
        end
    end

    //------------------------------------------------------------------
    // Stage 3: Q0.32 scaling to Q23.16 angle and Q13.16 rate, round half up, saturate.
    // Angle gain split in halves: total*gh + round(total*gl / 2^16) equals
    // round(total*gain / 2^16) since the high part is already integral.
    //------------------------------------------------------------------
    logic signed [PA_W-1:0]                w_pa_hi, w_pa_lo, w_pa_lo_b;
    logic signed [PA_W-mtft_pkg::Q_FRAC-1:0] w_lo_rnd;
    logic signed [SUM_W-1:0]               w_angle_sum;
    logic signed [mtft_pkg::ANGLE_W-1:0]   n_angle;
    logic signed [PR_W-1:0]                w_pr, w_pr_b;
    logic signed [PR_W-mtft_pkg::Q_FRAC-1:0] w_rate_rnd;
    logic signed [mtft_pkg::RATE_W-1:0]    n_rate;

    assign w_pa_hi = r_s2_total
                   * $signed({1'b0, r_angle_gain[mtft_pkg::GAIN_W-1:mtft_pkg::GAIN_H_W]});
    assign w_pa_lo = r_s2_total
                   * $signed({1'b0, r_angle_gain[mtft_pkg::GAIN_H_W-1:0]});
    assign w_pa_lo_b = w_pa_lo + PA_W'(mtft_pkg::ROUND_HALF);
    assign w_lo_rnd  = w_pa_lo_b[PA_W-1:mtft_pkg::Q_FRAC];
    assign w_angle_sum = SUM_W'(w_pa_hi) + SUM_W'(w_lo_rnd);

    always_comb begin
        if (w_angle_sum > SUM_W'(mtft_pkg::ANGLE_MAX)) begin
            n_angle = mtft_pkg::ANGLE_MAX;
        end else if (w_angle_sum < SUM_W'(mtft_pkg::ANGLE_MIN)) begin
            n_angle = mtft_pkg::ANGLE_MIN;
        end else begin
            n_angle = w_angle_sum[mtft_pkg::ANGLE_W-1:0];
        end
    end

    assign w_pr       = r_s2_speed * $signed({1'b0, r_rate_gain});
    assign w_pr_b     = w_pr + PR_W'(mtft_pkg::ROUND_HALF);
    assign w_rate_rnd = w_pr_b[PR_W-1:mtft_pkg::Q_FRAC];

    // Ticks carry no speed, rate reads zero
    always_comb begin
        if (r_s2_op == mtft_pkg::OP_TICK) begin
            n_rate = '0;
        end else if (w_rate_rnd > (PR_W - mtft_pkg::Q_FRAC)'(mtft_pkg::RATE_MAX)) begin
            n_rate = mtft_pkg::RATE_MAX;
        end else if (w_rate_rnd < (PR_W - mtft_pkg::Q_FRAC)'(mtft_pkg::RATE_MIN)) begin
            n_rate = mtft_pkg::RATE_MIN;
        end else begin
            n_rate = w_rate_rnd[mtft_pkg::RATE_W-1:0];
        end
    end

    logic signed [mtft_pkg::TOTAL_W-1:0]  r_s3_total;
    logic signed [mtft_pkg::ANGLE_W-1:0]  r_s3_angle;
    logic signed [mtft_pkg::RATE_W-1:0]   r_s3_rate;
    logic signed [mtft_pkg::TORQUE_W-1:0] r_s3_torque;
    logic [mtft_pkg::TEMP_W-1:0]          r_s3_temp;
    logic                                 r_s3_alive;

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_s3_total  <= r_s2_total;
            r_s3_angle  <= n_angle;
            r_s3_rate   <= n_rate;
            r_s3_torque <= r_s2_torque;
            r_s3_temp   <= r_s2_temp;
            r_s3_alive  <= r_s2_alive;
        end
    end

    // Output register drives the result channel directly
    assign o_res.valid           = r_s3_vld;
    assign o_res.total_count     = r_s3_total;
    assign o_res.angle_q16       = r_s3_angle;
    assign o_res.rate_q16        = r_s3_rate;
    assign o_res.torque_out      = r_s3_torque;
    assign o_res.temperature_out = r_s3_temp;
    assign o_res.link_alive      = r_s3_alive;

endmodule

// ===== design/mtft_chk.sv =====
// Port-level checker for the tracker, bound to the top level.
module mtft_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 i_in_ready,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic signed [mtft_pkg::TOTAL_W-1:0]  i_total,
    input logic signed [mtft_pkg::ANGLE_W-1:0]  i_angle,
    input logic signed [mtft_pkg::RATE_W-1:0]   i_rate
);

    // A stalled result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_total) && $stable(i_angle) && $stable(i_rate))
        else $error("result word changed while stalled");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // With the output draining, an accepted word reaches the output in time
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready ##1 i_out_ready ##1 i_out_ready |=> i_out_valid)
        else $error("accepted word did not reach the output");

    // An empty output register never blocks the input
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with output empty");

endmodule

bind multiturn_encoder_feedback_tracker mtft_chk u_mtft_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_fb.valid),
    .i_in_ready  (i_fb.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_total     (o_res.total_count),
    .i_angle     (o_res.angle_q16),
    .i_rate      (o_res.rate_q16)
);

// ===== tb/sv/tb_mtft_sb_pkg.sv =====
// Word types and scoreboard for the multi-turn encoder tracker testbench.
package tb_mtft_sb_pkg;
    import mtft_pkg::*;

    typedef struct packed {
        logic                opcode;
        logic [POS_W-1:0]    position;
        logic [SPEED_W-1:0]  speed;
        logic [TORQUE_W-1:0] torque;
        logic [TEMP_W-1:0]   temp;
    } t_fb_word;

    typedef struct packed {
        logic [TOTAL_W-1:0]  total;
        logic [ANGLE_W-1:0]  angle;
        logic [RATE_W-1:0]   rate;
        logic [TORQUE_W-1:0] torque;
        logic [TEMP_W-1:0]   temp;
        logic                alive;
    } t_fb_report;

    class feedback_scoreboard;
        // register copies
        longint      offset_cnt;
        bit [31:0]   angle_gain;
        bit [31:0]   rate_gain;
        // unwrap state
        bit [POS_W-1:0]    last_pos;
        longint            turns;
        bit                seen_frame;
        bit                alive;
        bit [TORQUE_W-1:0] torque;
        bit [TEMP_W-1:0]   temp;

        t_fb_report pending_reports[$];
        int         errors;
        int         shown;

        function new();
            offset_cnt = longint'(OFFSET_RST);
            angle_gain = ANGLE_GAIN_RST;
            rate_gain  = RATE_GAIN_RST;
            last_pos   = '0;
            turns      = 0;
            seen_frame = 1'b0;
            alive      = 1'b0;
            torque     = '0;
            temp       = '0;
            errors     = 0;
            shown      = 0;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        function longint sat(longint v, int w);
            longint hi;
            hi = (longint'(1) <<< (w - 1)) - 1;
            if (v > hi)
                return hi;
            if (v < -hi - 1)
                return -hi - 1;
            return v;
        endfunction

        // add half an LSB, then floor
        function longint round_q16(longint v);
            return (v + ROUND_HALF) >>> Q_FRAC;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_OFFSET:     offset_cnt = longint'($signed(value[OFS_W-1:0]));
                REG_ANGLE_GAIN: angle_gain = value;
                REG_RATE_GAIN:  rate_gain  = value;
                default: ;
            endcase
        endfunction

        function void predict_feedback(t_fb_word w);
            longint     delta;
            longint     t;
            longint     rate;
            longint     turn_top;
            t_fb_report e;
            rate     = 0;
            turn_top = (longint'(1) <<< (TURN_BITS - 1)) - 1;
            if (w.opcode == OP_FRAME) begin
                delta = longint'(w.position) - longint'(last_pos);
                if (delta < -(COUNTS_PER_TURN / 2)) begin
                    if (turns < turn_top)
                        turns++;
                end else if (delta > (COUNTS_PER_TURN / 2)) begin
                    if (turns > -turn_top - 1)
                        turns--;
                end
                last_pos   = w.position;
                torque     = w.torque;
                temp       = w.temp;
                seen_frame = 1'b1;
                rate = sat(round_q16(longint'($signed(w.speed)) * longint'(rate_gain)), RATE_W);
            end else begin
                alive      = seen_frame;
                seen_frame = 1'b0;
            end
            t = sat(turns * COUNTS_PER_TURN + longint'(last_pos) + offset_cnt, TOTAL_W);
            // 64-bit safe: split the gain into high and low halves
            e.total  = t[TOTAL_W-1:0];
            e.angle  = ANGLE_W'(sat(t * longint'(angle_gain[31:16])
                                    + round_q16(t * longint'(angle_gain[15:0])), ANGLE_W));
            e.rate   = rate[RATE_W-1:0];
            e.torque = torque;
            e.temp   = temp;
            e.alive  = alive;
            pending_reports.push_back(e);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("mismatch %s: expected %h got %h", field, want, got);
                end
            end
        endfunction

        function void check_report(t_fb_report got);
            t_fb_report e;
            if (pending_reports.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("result word with nothing pending: %h", got);
                end
                return;
            end
            e = pending_reports.pop_front();
            compare_field("total_count", 64'(e.total), 64'(got.total));
            compare_field("angle_q16", 64'(e.angle), 64'(got.angle));
            compare_field("rate_q16", 64'(e.rate), 64'(got.rate));
            compare_field("torque_out", 64'(e.torque), 64'(got.torque));
            compare_field("temperature_out", 64'(e.temp), 64'(got.temp));
            compare_field("link_alive", 64'(e.alive), 64'(got.alive));
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top-level testbench for the multi-turn encoder feedback tracker.
module tb_top;
    import mtft_pkg::*;
    import tb_mtft_sb_pkg::*;

    // nothing accepted for this many cycles means the block is stuck
    localparam int STALL_LIMIT = 3000;
    // long receiver hold-off, enough to fill the three pipeline stages
    localparam int HOLD_CYCLES = 120;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_BURSTY} t_rx_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    mtft_fb_if  fb();
    mtft_res_if res();

    multiturn_encoder_feedback_tracker uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fb    (fb),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    feedback_scoreboard sb;

    int idle_cycles = 0;    // cycles since anything was accepted
    int holdoff_req;        // bumped by the stimulus, served by the receiver
    int burst_left;         // words left in the current sender burst
    bit steady;             // sender offers back to back, no gaps
    int shaft;              // last position sent in a frame

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitor: sample both handshakes at the rising edge. Words go to the
    // predictor as they are accepted; result words are checked in order.
    always @(posedge i_clk) begin : monitor
        t_fb_word   w;
        t_fb_report r;
        bit         took;
        took = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (fb.valid === 1'b1 && fb.ready === 1'b1) begin
                w = {fb.opcode, fb.position_raw, fb.speed_rpm, fb.torque_raw, fb.temperature};
                sb.predict_feedback(w);
                took = 1'b1;
            end
            if (res.valid === 1'b1 && res.ready === 1'b1) begin
                r = {res.total_count, res.angle_q16, res.rate_q16, res.torque_out,
                     res.temperature_out, res.link_alive};
                sb.check_report(r);
                took = 1'b1;
            end
        end
        idle_cycles = took ? 0 : idle_cycles + 1;
    end

    // Watchdog
    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: switches between stall patterns of its own; serves hold-off
    // requests by keeping ready low for a long stretch.
    initial begin : receiver
        t_rx_mode mode;
        int       mode_left;
        int       stall_run;
        int       hold_done;
        res.ready = 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        stall_run = 0;
        hold_done = 0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req != hold_done) begin
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done++;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(40, 300);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:   res.ready <= 1'b1;
                    RX_COIN:     res.ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: res.ready <= (mode_left % 4 != 0);
                    default: begin
                        if (stall_run > 0) begin
                            res.ready <= 1'b0;
                            stall_run--;
                        end else begin
                            res.ready <= 1'b1;
                            if ($urandom_range(0, 9) == 0)
                                stall_run = $urandom_range(1, 12);
                        end
                    end
                endcase
            end
        end
    end

    // Field values that favor the extremes
    function automatic logic [15:0] any16();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] any8();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one word and hold it until accepted. Entered and left at a
    // falling edge. Gaps between bursts come before the word, never after.
    task automatic send_word(logic op, logic [POS_W-1:0] pos, logic [15:0] spd,
                             logic [15:0] trq, logic [7:0] tmp);
        if (!steady && burst_left == 0) begin
            fb.valid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? 30 : $urandom_range(1, 8))
                @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        fb.valid        <= 1'b1;
        fb.opcode       <= op;
        fb.position_raw <= pos;
        fb.speed_rpm    <= spd;
        fb.torque_raw   <= trq;
        fb.temperature  <= tmp;
        do
            @(posedge i_clk);
        while (fb.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic frame(int pos);
        send_word(OP_FRAME, pos[POS_W-1:0], any16(), any16(), any8());
        shaft = pos & (COUNTS_PER_TURN - 1);
    endtask

    // tick payload is don't-care; keep it random
    task automatic tick();
        send_word(OP_TICK, POS_W'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // Stop offering and wait until every result word is back, then let the
    // pipeline go quiet.
    task automatic settle();
        fb.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; write lands at the edge
    // that closes the access cycle.
    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    function automatic logic [31:0] pick_gain(logic [31:0] dflt);
        case ($urandom_range(0, 4))
            0:       return 32'h0;
            1:       return 32'hffff_ffff;
            2:       return dflt;
            default: return $urandom;
        endcase
    endfunction

    task automatic shuffle_config();
        logic [13:0] ofs;
        case ($urandom_range(0, 3))
            0:       ofs = 14'h2000;    // most negative
            1:       ofs = 14'h1fff;    // most positive
            2:       ofs = 14'h0000;
            default: ofs = 14'($urandom);
        endcase
        reg_write(REG_OFFSET, {{18{ofs[13]}}, ofs});
        reg_write(REG_ANGLE_GAIN, pick_gain(ANGLE_GAIN_RST));
        reg_write(REG_RATE_GAIN, pick_gain(RATE_GAIN_RST));
    endtask

    initial begin : stimulus
        int n;
        int sel;
        int vel;
        int steps[6];
        sb = new();
        i_rst_n         = 1'b0;
        fb.valid        = 1'b0;
        fb.opcode       = OP_FRAME;
        fb.position_raw = '0;
        fb.speed_rpm    = '0;
        fb.torque_raw   = '0;
        fb.temperature  = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        holdoff_req     = 0;
        burst_left      = 0;
        steady          = 1'b1;
        shaft           = 0;
        vel             = 0;
        steps           = '{4096, -4096, 4097, -4097, 4095, -4095};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed part, reset register values ----
        tick();                                                    // link down, all zero
        send_word(OP_FRAME, 13'd8191, 16'h7fff, 16'h7fff, 8'hff);  // first frame past half: one turn back
        send_word(OP_FRAME, 13'd4095, 16'h8000, 16'h8000, 8'h00);  // drop of exactly half: no turn
        send_word(OP_FRAME, 13'd8191, 16'hffff, 16'h0000, 8'h01);  // rise of exactly half: no turn
        send_word(OP_FRAME, 13'd0, 16'h0000, 16'h0001, 8'h80);     // wrap forward
        tick();                                                    // link alive
        tick();                                                    // no frame since: link down
        send_word(OP_FRAME, 13'd4097, 16'h0001, 16'hffff, 8'h7f);  // just over half up: back
        send_word(OP_FRAME, 13'd0, 16'h8001, 16'h7ffe, 8'hfe);     // just over half down: forward
        send_word(OP_FRAME, 13'd1, 16'h0000, 16'h0000, 8'h00);
        settle();

        // widest gains and offset: rate saturates both ways
        reg_write(REG_RATE_GAIN, 32'hffff_ffff);
        reg_write(REG_ANGLE_GAIN, 32'hffff_ffff);
        reg_write(REG_OFFSET, 32'h0000_1fff);
        send_word(OP_FRAME, 13'd8191, 16'h7fff, 16'h1234, 8'h55);
        send_word(OP_FRAME, 13'd8191, 16'h8000, 16'hedcb, 8'haa);
        send_word(OP_FRAME, 13'd0, 16'hffff, 16'h0000, 8'h00);
        send_word(OP_FRAME, 13'd0, 16'h0001, 16'h0000, 8'h00);
        tick();
        settle();

        // zero gains, most negative offset
        reg_write(REG_OFFSET, 32'hffff_e000);
        reg_write(REG_ANGLE_GAIN, 32'h0);
        reg_write(REG_RATE_GAIN, 32'h0);
        send_word(OP_FRAME, 13'd4096, 16'h7fff, 16'h8000, 8'hff);
        send_word(OP_FRAME, 13'd0, 16'h8000, 16'h7fff, 8'h00);
        tick();
        tick();
        settle();
        shaft = 0;

        // ---- random part: motion with random content, some noise ----
        for (int ph = 0; ph < 7; ph++) begin
            settle();
            shuffle_config();
            steady = (ph % 3 == 0);
            n = 100;
            for (int i = 0; i < n; i++) begin
                // long receiver hold-off while the sender keeps offering
                if (ph == 3 && i == n / 2)
                    holdoff_req++;
                sel = $urandom_range(0, 99);
                if (sel < 9) begin
                    tick();
                end else if (sel < 14) begin
                    frame($urandom_range(0, COUNTS_PER_TURN - 1));     // noise
                end else if (sel < 19) begin
                    frame(shaft + steps[$urandom_range(0, 5)]);        // on the threshold
                end else begin
                    if ($urandom_range(0, 19) == 0)
                        vel = $urandom_range(0, 8190) - 4095;
                    frame(shaft + vel + $urandom_range(0, 80) - 40);
                end
            end
        end

        // ---- spin toward the nearer end far enough to saturate the angle ----
        settle();
        reg_write(REG_ANGLE_GAIN, 32'hffff_ffff);
        reg_write(REG_RATE_GAIN, pick_gain(RATE_GAIN_RST));
        steady = 1'b1;
        if (sb.turns >= 0) begin
            while (sb.turns < 560) begin
                if ($urandom_range(0, 39) == 0)
                    tick();
                else
                    frame(shaft + $urandom_range(4080, 4095));
            end
        end else begin
            while (sb.turns > -560) begin
                if ($urandom_range(0, 39) == 0)
                    tick();
                else
                    frame(shaft - $urandom_range(4080, 4095));
            end
        end
        steady = 1'b0;
        settle();
        reg_write(REG_ANGLE_GAIN, 32'($urandom));
        for (int i = 0; i < 40; i++) begin
            if ($urandom_range(0, 4) == 0)
                tick();
            else
                frame(shaft + $urandom_range(0, 200) - 100);
        end

        // ---- wind down ----
        settle();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
